/* hdl/smag_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smag_pkg
// Shared widths and types for the strain rate magnitude pipeline.
// ----------------------------------------------------------------------------
package smag_pkg;

  localparam int DataW  = 32;
  localparam int FracW  = 16;
  localparam int MagW   = DataW - 1;
  localparam int RootW  = 24;               // sqrt of a 47 bit radicand
  localparam int RadW   = 2 * RootW;
  localparam int RemW   = RootW + 2;
  localparam int ProdW  = RootW + DataW + 1;
  localparam int ShW    = ProdW - FracW;
  localparam int InW    = 8 * DataW;
  localparam int OutW   = ((MagW + 8 * DataW + 7) / 8) * 8;

  typedef struct packed {
    logic signed [DataW-1:0] xx;
    logic signed [DataW-1:0] yy;
    logic signed [DataW-1:0] zz;
    logic signed [DataW-1:0] xy;
    logic signed [DataW-1:0] xz;
    logic signed [DataW-1:0] yz;
  } comp_t;

  typedef struct packed {
    logic             vld;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [RadW-1:0]  rad;
    comp_t            c;
  } cell_t;

endpackage

/* hdl/smag_square.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smag_square
// Face centring, saturated squares and the weighted sum feeding the root row.
// ----------------------------------------------------------------------------
module smag_square import smag_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [InW-1:0]   data_i,
  output cell_t            cell_o
);

  localparam logic [MagW-1:0] MaxP = {MagW{1'b1}};

  function automatic logic [MagW-1:0] sq_sat(input logic signed [DataW-1:0] x);
    logic [DataW-1:0]   m;
    logic [2*DataW-1:0] p;
    m = x[DataW-1] ? DataW'(-x) : DataW'(x);
    p = m * m;
    if (p[2*DataW-1:FracW+MagW] != '0) sq_sat = MaxP;
    else                                sq_sat = p[FracW+MagW-1:FracW];
  endfunction

  logic signed [DataW:0] sum_xz, sum_yz;
  comp_t                 c_in;
  logic                  vld1_q;
  comp_t                 c1_q;
  logic [MagW-1:0]       sq_q [6];
  logic [MagW+4:0]       wsum;
  logic [MagW-1:0]       wsat;

  always_comb begin
    sum_xz  = $signed({data_i[5*DataW-1], data_i[5*DataW-1 -: DataW]})
            + $signed({data_i[6*DataW-1], data_i[6*DataW-1 -: DataW]});
    sum_yz  = $signed({data_i[7*DataW-1], data_i[7*DataW-1 -: DataW]})
            + $signed({data_i[8*DataW-1], data_i[8*DataW-1 -: DataW]});
    c_in.xx = data_i[1*DataW-1 -: DataW];
    c_in.yy = data_i[2*DataW-1 -: DataW];
    c_in.zz = data_i[3*DataW-1 -: DataW];
    c_in.xy = data_i[4*DataW-1 -: DataW];
    // floor halving of the face pair
    c_in.xz = sum_xz[DataW:1];
    c_in.yz = sum_yz[DataW:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q     <= c_in;
      sq_q[0]  <= sq_sat(c_in.xx);
      sq_q[1]  <= sq_sat(c_in.yy);
      sq_q[2]  <= sq_sat(c_in.zz);
      sq_q[3]  <= sq_sat(c_in.xy);
      sq_q[4]  <= sq_sat(c_in.xz);
      sq_q[5]  <= sq_sat(c_in.yz);
    end
  end

  always_comb begin
    wsum = ((MagW+5)'(sq_q[0]) + (MagW+5)'(sq_q[1]) + (MagW+5)'(sq_q[2])) << 1;
    wsum = wsum + (((MagW+5)'(sq_q[3]) + (MagW+5)'(sq_q[4])
                  + (MagW+5)'(sq_q[5])) << 2);
    wsat = (wsum[MagW+4:MagW] != '0) ? MaxP : wsum[MagW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_o <= '0;
    end else if (en_i) begin
      cell_o.vld  <= vld1_q;
      cell_o.rem  <= '0;
      cell_o.root <= '0;
      cell_o.rad  <= {1'b0, wsat, {FracW{1'b0}}};
      cell_o.c    <= c1_q;
    end
  end

endmodule

/* hdl/smag_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smag_sqrt_cell
// One root bit: brings down two radicand bits and tries the next digit.
// ----------------------------------------------------------------------------
module smag_sqrt_cell import smag_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  cell_t cell_i,
  output cell_t cell_o
);

  logic [RemW+1:0] sh, trial;
  cell_t           cell_d;

  always_comb begin
    sh     = {cell_i.rem, cell_i.rad[RadW-1 -: 2]};
    trial  = {2'b00, cell_i.root, 2'b01};
    cell_d = cell_i;
    cell_d.rad = cell_i.rad << 2;
    if (sh >= trial) begin
      cell_d.rem  = RemW'(sh - trial);
      cell_d.root = {cell_i.root[RootW-2:0], 1'b1};
    end else begin
      cell_d.rem  = RemW'(sh);
      cell_d.root = {cell_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_o <= '0;
    end else if (en_i) begin
      cell_o <= cell_d;
    end
  end

endmodule

/* hdl/smag_product.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smag_product
// Magnitude times each tensor component, floored and saturated.
// ----------------------------------------------------------------------------
module smag_product import smag_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cell_t              cell_i,
  output logic               vld_o,
  output logic [OutW-1:0]    data_o
);

  localparam logic signed [DataW-1:0] MaxS = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] MinS = {1'b1, {(DataW-1){1'b0}}};

  function automatic logic signed [DataW-1:0] fix_sat(input logic signed [ProdW-1:0] p);
    logic signed [ShW-1:0] s;
    s = ShW'(p >>> FracW);
    if (s[ShW-1:DataW-1] == '0 || s[ShW-1:DataW-1] == '1) fix_sat = s[DataW-1:0];
    else if (s[ShW-1])                                    fix_sat = MinS;
    else                                                  fix_sat = MaxS;
  endfunction

  logic signed [ProdW-1:0] p_q [6];
  logic [RootW-1:0]        root_q;
  comp_t                   c_q;
  logic signed [RootW:0]   m_s;

  assign m_s = $signed({1'b0, cell_i.root});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= cell_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= cell_i.root;
      c_q    <= cell_i.c;
      p_q[0] <= m_s * cell_i.c.xx;
      p_q[1] <= m_s * cell_i.c.xy;
      p_q[2] <= m_s * cell_i.c.xz;
      p_q[3] <= m_s * cell_i.c.yy;
      p_q[4] <= m_s * cell_i.c.yz;
      p_q[5] <= m_s * cell_i.c.zz;
    end
  end

  assign data_o = {{(OutW-MagW-8*DataW){1'b0}},
                   fix_sat(p_q[5]), fix_sat(p_q[4]), fix_sat(p_q[3]),
                   fix_sat(p_q[2]), fix_sat(p_q[1]), fix_sat(p_q[0]),
                   c_q.yz, c_q.xz, MagW'(root_q)};

endmodule

/* hdl/strain_magnitude_tensor_product.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strain_magnitude_tensor_product
// Strain rate magnitude |S| and the six |S|-weighted strain components.
// ----------------------------------------------------------------------------
// One item per clock while the output is not stalled. In order, the stages are
// centring, squaring and summing, a row of 24 square root cells, one per root
// bit, the six products and the output register. The whole pipeline stalls
// together while the output register holds an unread item.
module strain_magnitude_tensor_product import smag_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // s_xx, s_yy, s_zz, s_xy, s_xz_below, s_xz_here, s_yz_below, s_yz_here
  input  logic [InW-1:0]  s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // strain_mag, shear_xz_centre, shear_yz_centre, prod_xx, prod_xy, prod_xz,
  // prod_yy, prod_yz, prod_zz, zero pad
  output logic [OutW-1:0] m_axis_tdata
);

  logic            en;
  cell_t           chain [RootW+1];
  logic            res_vld;
  logic [OutW-1:0] res_data;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  smag_square u_square (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_axis_tvalid),
    .data_i(s_axis_tdata), .cell_o(chain[0])
  );

  for (genvar i = 0; i < RootW; i++) begin : g_root
    smag_sqrt_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .cell_i(chain[i]), .cell_o(chain[i+1])
    );
  end

  smag_product u_product (
    .clk_i, .rst_ni, .en_i(en), .cell_i(chain[RootW]),
    .vld_o(res_vld), .data_o(res_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= res_data;
    end
  end

endmodule

/* hdl/smag_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smag_checker
// Port level checks for the strain magnitude block.
// ----------------------------------------------------------------------------
module smag_checker import smag_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata
);

  // input side only stalls while a result waits
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == !(m_axis_tvalid && !m_axis_tready))
    else $error("input ready does not follow output stall");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // zero magnitude gives zero products
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[MagW-1:0] == '0 |->
      m_axis_tdata[OutW-1:MagW+2*DataW] == '0)
    else $error("nonzero product with zero magnitude");

endmodule

bind strain_magnitude_tensor_product smag_checker u_smag_checker (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
